FILE: rtl/assert_macros.svh
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_RAW(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/caldate_pkg.sv
package caldate_pkg;

  localparam int FUNC_W  = 3;
  localparam int VALUE_W = 14;
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int WDAY_W  = 3;

  localparam int DEF_MAX_YEAR = 9999;

  localparam logic [FUNC_W-1:0] FN_NEXT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PREV = 3'd1;
  localparam logic [FUNC_W-1:0] FN_ADD  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_SETD = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SETM = 3'd4;
  localparam logic [FUNC_W-1:0] FN_SETY = 3'd5;

  typedef struct packed {
    logic load;
    logic exec;
    logic step;
    logic add_fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;
    logic add_done;
  } dp_stat_t;

endpackage

FILE: rtl/caldate_ctrl.sv
module caldate_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  caldate_pkg::dp_stat_t stat,
  output caldate_pkg::dp_cmd_t  cmd
);
  import caldate_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_EXEC, S_ADD, S_WK0, S_WK1, S_WK2, S_DONE
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE:  cmd.load     = in_valid;
      S_EXEC:  cmd.exec     = 1'b1;
      S_ADD: begin
        cmd.step    = !stat.add_done;
        cmd.add_fin = stat.add_done;
      end
      S_DONE:  cmd.out_load = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:  if (in_valid) state <= S_PREP;
        S_PREP:  state <= stat.is_add ? S_ADD : S_EXEC;
        S_EXEC:  state <= S_WK0;
        S_ADD:   if (stat.add_done) state <= S_WK0;
        S_WK0:   state <= S_WK1;
        S_WK1:   state <= S_WK2;
        S_WK2:   state <= S_DONE;
        S_DONE:  if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/caldate_dp.sv
module caldate_dp #(
  parameter int MAX_YEAR = caldate_pkg::DEF_MAX_YEAR
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [caldate_pkg::FUNC_W-1:0]    func,
  input  logic [caldate_pkg::VALUE_W-1:0]   value,
  input  caldate_pkg::dp_cmd_t              cmd,
  output caldate_pkg::dp_stat_t             stat,
  output logic [caldate_pkg::DAY_W-1:0]     cur_day,
  output logic [caldate_pkg::MONTH_W-1:0]   cur_month,
  output logic [caldate_pkg::YEAR_W-1:0]    cur_year,
  output logic [caldate_pkg::WDAY_W-1:0]    weekday,
  output logic                              accepted
);
  import caldate_pkg::*;

  localparam int WD_W = YEAR_W + 1;
  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(MAX_YEAR);
  localparam logic [12:0] RECIP100 = 13'd5243;   // 2^19 / 100, rounded up
  localparam logic [14:0] RECIP7   = 15'd18725;  // 2^17 / 7, rounded up

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [26:0]       p;
    logic [7:0]        q;
    logic [YEAR_W-1:0] r;
    p = 27'(y) * 27'(RECIP100);
    q = p[26:19];
    r = y - YEAR_W'(YEAR_W'(q) * YEAR_W'(100));
    return ((y[1:0] == 2'd0) && (r != '0)) || ((r == '0) && (q[1:0] == 2'd0));
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    return 5'd30;
      4'd2:                                       return leap ? 5'd29 : 5'd28;
      default:                                    return 5'd0;
    endcase
  endfunction

  // (2m + 3(m+1)/5) mod 7, Jan/Feb counted as months 13/14
  function automatic logic [2:0] month_term(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    return 3'd6;
      4'd2:    return 3'd2;
      4'd3:    return 3'd1;
      4'd4:    return 3'd4;
      4'd5:    return 3'd6;
      4'd6:    return 3'd2;
      4'd7:    return 3'd4;
      4'd8:    return 3'd0;
      4'd9:    return 3'd3;
      4'd10:   return 3'd5;
      4'd11:   return 3'd1;
      4'd12:   return 3'd3;
      default: return 3'd0;
    endcase
  endfunction

  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;

  logic [FUNC_W-1:0]  func_r;
  logic [WD_W-1:0]    wd;
  logic [MONTH_W-1:0] wm;
  logic [YEAR_W-1:0]  wy;
  logic               wleap;
  logic               mbad;
  logic               add_fail;
  logic               ok_r;

  logic [WD_W-1:0]    mlen_x;
  logic [WD_W-1:0]    nd;
  logic [MONTH_W-1:0] nm;
  logic [YEAR_W-1:0]  ny;
  logic               exec_ok;
  logic               commit;

  logic [YEAR_W-1:0]  yp;
  logic [YEAR_W-1:0]  yp_r;
  logic [26:0]        p100_r;
  logic [24:0]        p400_r;
  logic [DAY_W-1:0]   dd_r;
  logic [2:0]         mt_r;
  logic [WD_W-1:0]    s_r;
  logic [29:0]        pm_r;
  logic [WD_W-1:0]    wk;

  assign mlen_x = WD_W'(month_len(wm, wleap));

  assign stat.is_add   = (func_r == FN_ADD);
  assign stat.add_done = add_fail || (wd <= mlen_x);

  always_comb begin
    nd      = wd;
    nm      = wm;
    ny      = wy;
    exec_ok = 1'b0;
    case (func_r)
      FN_NEXT: begin
        exec_ok = 1'b1;
        if (wd == mlen_x) begin
          nd = WD_W'(1);
          if (wm == 4'd12) begin
            if (wy == YMAX) begin
              exec_ok = 1'b0;
            end else begin
              nm = 4'd1;
              ny = wy + YEAR_W'(1);
            end
          end else begin
            nm = wm + 4'd1;
          end
        end else begin
          nd = wd + WD_W'(1);
        end
      end
      FN_PREV: begin
        exec_ok = 1'b1;
        if (wd > WD_W'(1)) begin
          nd = wd - WD_W'(1);
        end else if (wm > 4'd1) begin
          nm = wm - 4'd1;
          nd = WD_W'(month_len(wm - 4'd1, wleap));
        end else if (wy == YEAR_W'(1)) begin
          exec_ok = 1'b0;
        end else begin
          nm = 4'd12;
          nd = WD_W'(31);
          ny = wy - YEAR_W'(1);
        end
      end
      FN_SETD: exec_ok = (wd >= WD_W'(1)) && (wd <= mlen_x);
      FN_SETM: exec_ok = !mbad && (wd <= mlen_x);
      FN_SETY: exec_ok = (wy >= YEAR_W'(1)) && (wy <= YMAX) && (wd <= mlen_x);
      default: exec_ok = 1'b0;
    endcase
  end

  assign commit = (cmd.exec && exec_ok) || (cmd.add_fin && !add_fail);

  always_ff @(posedge clk) begin
    if (rst) begin
      day   <= DAY_W'(1);
      month <= MONTH_W'(1);
      year  <= YEAR_W'(1);
    end else if (cmd.exec && exec_ok) begin
      day   <= nd[DAY_W-1:0];
      month <= nm;
      year  <= ny;
    end else if (commit) begin
      day   <= wd[DAY_W-1:0];
      month <= wm;
      year  <= wy;
    end
  end

  // working copy of the date; the leap flag is registered from the working year
  always_ff @(posedge clk) begin
    wleap <= is_leap(wy);
    if (cmd.load) begin
      func_r   <= func;
      add_fail <= 1'b0;
      mbad     <= (func == FN_SETM) && (value[VALUE_W-1:MONTH_W] != '0);
      wm       <= (func == FN_SETM) ? value[MONTH_W-1:0] : month;
      wy       <= (func == FN_SETY) ? value : year;
      case (func)
        FN_ADD:  wd <= WD_W'(day) + WD_W'(value);
        FN_SETD: wd <= WD_W'(value);
        default: wd <= WD_W'(day);
      endcase
    end else if (cmd.step) begin
      wd <= wd - mlen_x;
      if (wm == 4'd12) begin
        if (wy == YMAX) begin
          add_fail <= 1'b1;
        end else begin
          wm <= 4'd1;
          wy <= wy + YEAR_W'(1);
        end
      end else begin
        wm <= wm + 4'd1;
      end
    end
    if (cmd.exec) begin
      ok_r <= exec_ok;
    end else if (cmd.add_fin) begin
      ok_r <= !add_fail;
    end
  end

  // weekday pipeline on the committed date
  assign yp = (month <= 4'd2) ? year - YEAR_W'(1) : year;
  assign wk = s_r - WD_W'(WD_W'(pm_r[29:17]) * WD_W'(7));

  always_ff @(posedge clk) begin
    yp_r   <= yp;
    dd_r   <= day;
    mt_r   <= month_term(month);
    p100_r <= 27'(yp) * 27'(RECIP100);
    p400_r <= 25'(yp[YEAR_W-1:2]) * 25'(RECIP100);
    s_r    <= WD_W'(dd_r) + WD_W'(mt_r) + WD_W'(yp_r) + WD_W'(yp_r[YEAR_W-1:2])
              - WD_W'(p100_r[26:19]) + WD_W'(p400_r[24:19]);
    pm_r   <= 30'(s_r) * 30'(RECIP7);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cur_day   <= day;
      cur_month <= month;
      cur_year  <= year;
      weekday   <= wk[WDAY_W-1:0];
      accepted  <= ok_r;
    end
  end

endmodule

FILE: rtl/calendar_date_counter.sv
// Gregorian date counter, reset to 1 January of year 1.
// Input channel in_valid/in_ready carries one word: func and value.
// func: next day, previous day, add value days, set day, set month, set year.
// Output channel out_valid/out_ready returns one word per input word: the
// date after the operation, its weekday (0 = Monday) and an accepted flag.
// Refused operations (invalid date, year outside 1..MAX_YEAR) keep the date.
// One word at a time: in_ready is high only when idle, so a new word is
// taken only after the last result is loaded into the output register.
// Every function passes through the states PREP, EXEC, WK0, WK1, WK2 and
// DONE before out_valid is set; add uses ADD in place of EXEC and stays
// there until every month boundary is crossed. The add loop steps one
// month per cycle through a single subtract/compare unit; the weekday comes
// from a three-stage multiply pipeline after the date is updated.
// A new word can be taken in the cycle after the result is loaded into the
// output register, so while that register waits for out_ready the next word
// is still accepted and computed; it stalls only in its final cycle until
// the receiver takes the waiting word.
// Reset (synchronous, active high) returns the date to 1/1/1, clears
// out_valid and leaves the block idle.
module calendar_date_counter #(
  parameter int MAX_YEAR = caldate_pkg::DEF_MAX_YEAR
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [caldate_pkg::FUNC_W-1:0]    func,
  input  logic [caldate_pkg::VALUE_W-1:0]   value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [caldate_pkg::DAY_W-1:0]     cur_day,
  output logic [caldate_pkg::MONTH_W-1:0]   cur_month,
  output logic [caldate_pkg::YEAR_W-1:0]    cur_year,
  output logic [caldate_pkg::WDAY_W-1:0]    weekday,
  output logic                              accepted
);
  import caldate_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  caldate_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  caldate_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .func      (func),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .cur_day   (cur_day),
    .cur_month (cur_month),
    .cur_year  (cur_year),
    .weekday   (weekday),
    .accepted  (accepted)
  );

endmodule

FILE: rtl/caldate_checker.sv
`include "assert_macros.svh"

module caldate_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [caldate_pkg::DAY_W-1:0]     cur_day,
  input logic [caldate_pkg::MONTH_W-1:0]   cur_month,
  input logic [caldate_pkg::YEAR_W-1:0]    cur_year,
  input logic [caldate_pkg::WDAY_W-1:0]    weekday,
  input logic                              accepted
);
  import caldate_pkg::*;

  `ASSERT_CLK(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(cur_day) && $stable(cur_month)
      && $stable(cur_year) && $stable(weekday) && $stable(accepted),
    "result word changed while stalled")

  `ASSERT_CLK(a_date_range,
    out_valid |-> cur_day != 0 && cur_month != 0 && cur_month <= 12 && cur_year != 0,
    "result date out of range")

  `ASSERT_CLK(a_weekday_range, out_valid |-> weekday <= 6, "weekday out of range")

  `ASSERT_CLK(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second word taken while busy")

  `ASSERT_RAW(a_reset_state, rst |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind calendar_date_counter caldate_checker u_caldate_checker (.*);
